// File: hw/rtl/rgbcc_pkg.sv
// shared types, constants and gamma tables for the rgb color correction pipeline
package rgbcc_pkg;

  localparam int CH_W     = 13;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W   = 16;
  localparam int ROM_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CCM_R = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CCM_G = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CCM_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EXPO  = 3'd7;

  localparam int MB_LIN  = 0;
  localparam int MB_WB   = 1;
  localparam int MB_LUMA = 2;
  localparam int MB_CCM  = 3;
  localparam int MB_CENC = 4;
  localparam int MB_OFFS = 5;
  localparam int MB_EXPO = 6;

  typedef logic [6:0] mode_t;

  function automatic logic [ROM_W-1:0] decode_rom(input logic [5:0] i);
    logic [ROM_W-1:0] r;
    case (i)
      6'd0: r = 17'd0;      6'd1: r = 17'd32;     6'd2: r = 17'd147;
      6'd3: r = 17'd359;    6'd4: r = 17'd676;    6'd5: r = 17'd1104;
      6'd6: r = 17'd1648;   6'd7: r = 17'd2314;   6'd8: r = 17'd3104;
      6'd9: r = 17'd4022;   6'd10: r = 17'd5072;  6'd11: r = 17'd6255;
      6'd12: r = 17'd7574;  6'd13: r = 17'd9033;  6'd14: r = 17'd10632;
      6'd15: r = 17'd12375; 6'd16: r = 17'd14263; 6'd17: r = 17'd16298;
      6'd18: r = 17'd18482; 6'd19: r = 17'd20817; 6'd20: r = 17'd23303;
      6'd21: r = 17'd25880; 6'd22: r = 17'd28739; 6'd23: r = 17'd31692;
      6'd24: r = 17'd34803; 6'd25: r = 17'd38073; 6'd26: r = 17'd41504;
      6'd27: r = 17'd45097; 6'd28: r = 17'd48854; 6'd29: r = 17'd52774;
      6'd30: r = 17'd56861; 6'd31: r = 17'd61115;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [ROM_W-1:0] encode_rom(input logic [5:0] i);
    logic [ROM_W-1:0] r;
    case (i)
      6'd0: r = 17'd0;      6'd1: r = 17'd13562;  6'd2: r = 17'd18585;
      6'd3: r = 17'd22346;  6'd4: r = 17'd25405;  6'd5: r = 17'd28186;
      6'd6: r = 17'd30621;  6'd7: r = 17'd32844;  6'd8: r = 17'd34899;
      6'd9: r = 17'd36819;  6'd10: r = 17'd38625; 6'd11: r = 17'd40335;
      6'd12: r = 17'd41962; 6'd13: r = 17'd43517; 6'd14: r = 17'd45008;
      6'd15: r = 17'd46442; 6'd16: r = 17'd47824; 6'd17: r = 17'd49160;
      6'd18: r = 17'd50454; 6'd19: r = 17'd51710; 6'd20: r = 17'd52929;
      6'd21: r = 17'd54117; 6'd22: r = 17'd55273; 6'd23: r = 17'd56401;
      6'd24: r = 17'd57503; 6'd25: r = 17'd58580; 6'd26: r = 17'd59634;
      6'd27: r = 17'd60665; 6'd28: r = 17'd61677; 6'd29: r = 17'd62668;
      6'd30: r = 17'd63641; 6'd31: r = 17'd64597;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/rgbcc_gamma.sv
// two-stage gamma table lookup with linear interpolation, one channel
module rgbcc_gamma
  import rgbcc_pkg::*;
#(
  parameter int PIXEL_FRAC_BITS = 12,
  parameter bit ENCODE = 1'b0
) (
  input  logic                     clk,
  input  logic [PIXEL_FRAC_BITS:0] v_in,
  output logic [PIXEL_FRAC_BITS:0] v_out
);

  localparam int PW = PIXEL_FRAC_BITS + 1;
  localparam int FB = PIXEL_FRAC_BITS - 5;
  localparam int PROD_W = ROM_W + FB;

  logic [5:0]       idx;
  logic [FB-1:0]    frac;
  logic [ROM_W-1:0] lo, hi;
  logic [ROM_W-1:0] lo_r, diff_r;
  logic [FB-1:0]    frac_r;
  logic [PROD_W-1:0] prod;
  logic [ROM_W-1:0] q16;
  logic [ROM_W+PIXEL_FRAC_BITS:0] scaled;

  // v*32/ONE: index is top bits, remainder in units of 1/ONE is low bits << 5
  assign idx  = 6'(v_in >> FB);
  assign frac = v_in[FB-1:0];

  always_comb begin
    if (ENCODE) begin
      lo = encode_rom(idx);
      hi = encode_rom(6'(idx + 6'd1));
    end else begin
      lo = decode_rom(idx);
      hi = decode_rom(6'(idx + 6'd1));
    end
    if (idx >= 6'd32) begin
      hi = lo;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo;
    diff_r <= hi - lo;
    frac_r <= frac;
  end

  assign prod   = PROD_W'(diff_r) * PROD_W'(frac_r);
  assign q16    = lo_r + ROM_W'(prod >> FB);
  assign scaled = ((ROM_W+PIXEL_FRAC_BITS+1)'(q16) << PIXEL_FRAC_BITS)
                  + (ROM_W+PIXEL_FRAC_BITS+1)'(32768);

  always_ff @(posedge clk) begin
    v_out <= PW'(scaled >> 16);
  end

endmodule

// File: hw/rtl/rgb_color_correction_pipeline_top.sv
// rgb color correction pipeline top level: gamma, gains, color matrix, exposure
// one item per cycle sustained; out_valid follows start through the valid shift register
// each step is a fixed register slice; bypassed steps still take their cycles
// reset (rst_n low, synchronous) clears valid bits and restores register defaults
// no backpressure: results appear on out_valid for one cycle and must be taken
module rgb_color_correction_pipeline_top
  import rgbcc_pkg::*;
#(
  parameter int PIXEL_FRAC_BITS = 12,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CH_W-1:0]      in_red_in,
  input  logic [CH_W-1:0]      in_green_in,
  input  logic [CH_W-1:0]      in_blue_in,
  output logic                 out_valid,
  output logic [CH_W-1:0]      out_red_out,
  output logic [CH_W-1:0]      out_green_out,
  output logic [CH_W-1:0]      out_blue_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PW = PIXEL_FRAC_BITS + 1;
  localparam logic [PW-1:0] ONE = PW'(1) << PIXEL_FRAC_BITS;
  localparam int GP_W = PW + GAIN_W;
  localparam int MS_W = PW + GAIN_W + 4;
  localparam int NST = 14;

  typedef logic [PW-1:0] px_t;
  typedef px_t [2:0] pix_t;

  mode_t          mode_r;
  logic [CFG_W-1:0] wb_r, ccm_r_r, ccm_g_r, ccm_b_r, offs_r;
  logic [GAIN_W-1:0] luma_r, expo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      wb_r    <= '0;
      luma_r  <= GAIN_W'(1) << GAIN_FRAC_BITS;
      ccm_r_r <= '0;
      ccm_g_r <= '0;
      ccm_b_r <= '0;
      offs_r  <= '0;
      expo_r  <= GAIN_W'(1) << GAIN_FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[6:0];
        REG_WB:    wb_r    <= cfg_data;
        REG_LUMA:  luma_r  <= cfg_data[GAIN_W-1:0];
        REG_CCM_R: ccm_r_r <= cfg_data;
        REG_CCM_G: ccm_g_r <= cfg_data;
        REG_CCM_B: ccm_b_r <= cfg_data;
        REG_OFFS:  offs_r  <= cfg_data;
        REG_EXPO:  expo_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [NST-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[NST-2:0], start & ~busy};
  end
  assign out_valid = vld_r[NST-1];

  function automatic px_t sat_in(input logic [CH_W-1:0] v);
    return (int'(v) > int'(ONE)) ? ONE : PW'(v);
  endfunction

  function automatic px_t round_gain(input logic [GP_W-1:0] p);
    logic [GP_W-1:0] q;
    q = (p + (GP_W'(1) << (GAIN_FRAC_BITS-1))) >> GAIN_FRAC_BITS;
    return (q > GP_W'(ONE)) ? ONE : PW'(q);
  endfunction

  // stage 0: input saturation
  pix_t s0_r;
  always_ff @(posedge clk) begin
    s0_r[0] <= sat_in(in_red_in);
    s0_r[1] <= sat_in(in_green_in);
    s0_r[2] <= sat_in(in_blue_in);
  end

  // stages 1-2: decode
  pix_t dec_o, s2;
  for (genvar c = 0; c < 3; c++) begin : g_dec
    rgbcc_gamma #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS), .ENCODE(1'b0)) u_dec (
      .clk(clk), .v_in(s0_r[c]), .v_out(dec_o[c]));
  end
  pix_t s0_d1_r, s0_d2_r;
  always_ff @(posedge clk) begin
    s0_d1_r <= s0_r;
    s0_d2_r <= s0_d1_r;
  end
  assign s2 = mode_r[MB_LIN] ? dec_o : s0_d2_r;

  // stages 3-4: white balance
  logic [2:0][GP_W-1:0] wbp_r;
  pix_t s2_d_r, s4_r;
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      wbp_r[c] <= GP_W'(s2[c]) * GP_W'(wb_r[16*c +: GAIN_W]);
    end
    s2_d_r <= s2;
    for (int c = 0; c < 3; c++) begin
      s4_r[c] <= mode_r[MB_WB] ? round_gain(wbp_r[c]) : s2_d_r[c];
    end
  end

  // luma gain
  logic [2:0][GP_W-1:0] lp_r;
  pix_t s4_d_r, s6;
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      lp_r[c] <= GP_W'(s4_r[c]) * GP_W'(luma_r);
    end
    s4_d_r <= s4_r;
  end
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s6[c] = mode_r[MB_LUMA] ? round_gain(lp_r[c]) : s4_d_r[c];
    end
  end

  // encode ahead of the matrix
  pix_t cenc_o, s8;
  for (genvar c = 0; c < 3; c++) begin : g_cenc
    rgbcc_gamma #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS), .ENCODE(1'b1)) u_cenc (
      .clk(clk), .v_in(s6[c]), .v_out(cenc_o[c]));
  end
  pix_t s6_d1_r, s6_d2_r;
  always_ff @(posedge clk) begin
    s6_d1_r <= s6;
    s6_d2_r <= s6_d1_r;
  end
  assign s8 = (mode_r[MB_CCM] && mode_r[MB_CENC]) ? cenc_o : s6_d2_r;

  // color matrix, products then sum
  logic [2:0][2:0][MS_W-1:0] mp_r;
  logic [2:0][MS_W-1:0] mo_r;
  pix_t s8_d_r, s10;
  logic [CFG_W-1:0] coefs [3];
  assign coefs[0] = ccm_r_r;
  assign coefs[1] = ccm_g_r;
  assign coefs[2] = ccm_b_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        mp_r[k][c] <= MS_W'($signed(coefs[k][16*c +: 16]))
                      * MS_W'($signed({1'b0, s8[c]}));
      end
      mo_r[k] <= mode_r[MB_OFFS]
                 ? MS_W'($signed(offs_r[16*k +: 16])) * MS_W'($signed({1'b0, ONE}))
                 : '0;
    end
    s8_d_r <= s8;
  end
  always_comb begin
    logic signed [MS_W-1:0] sum;
    logic [MS_W-1:0] q;
    for (int k = 0; k < 3; k++) begin
      sum = $signed(mp_r[k][0]) + $signed(mp_r[k][1]) + $signed(mp_r[k][2])
            + $signed(mo_r[k]);
      q = (MS_W'(sum) + (MS_W'(1) << (GAIN_FRAC_BITS-1))) >> GAIN_FRAC_BITS;
      if (!mode_r[MB_CCM]) s10[k] = s8_d_r[k];
      else if (sum <= 0) s10[k] = '0;
      else s10[k] = (q > MS_W'(ONE)) ? ONE : PW'(q);
    end
  end

  // exit encode
  pix_t xenc_o, s12;
  pix_t s10_r;
  always_ff @(posedge clk) s10_r <= s10;
  for (genvar c = 0; c < 3; c++) begin : g_xenc
    rgbcc_gamma #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS), .ENCODE(1'b1)) u_xenc (
      .clk(clk), .v_in(s10_r[c]), .v_out(xenc_o[c]));
  end
  pix_t s10_d1_r, s10_d2_r;
  always_ff @(posedge clk) begin
    s10_d1_r <= s10_r;
    s10_d2_r <= s10_d1_r;
  end
  assign s12 = mode_r[MB_LIN] ? xenc_o : s10_d2_r;

  // exposure
  logic [2:0][GP_W-1:0] ep_r;
  pix_t s12_d_r, res_r;
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      ep_r[c] <= GP_W'(s12[c]) * GP_W'(expo_r);
    end
    s12_d_r <= s12;
    for (int c = 0; c < 3; c++) begin
      res_r[c] <= mode_r[MB_EXPO] ? round_gain(ep_r[c]) : s12_d_r[c];
    end
  end

  assign out_red_out   = CH_W'(res_r[0]);
  assign out_green_out = CH_W'(res_r[1]);
  assign out_blue_out  = CH_W'(res_r[2]);

endmodule

// File: hw/rtl/rgbcc_checker.sv
// port-level checks for the rgb color correction pipeline
module rgbcc_checker
  import rgbcc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input logic [CH_W-1:0] out_red_out,
  input logic [CH_W-1:0] out_green_out,
  input logic [CH_W-1:0] out_blue_out
);

  localparam int LAT = 14;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("item result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, LAT) && !$past(start, LAT)) |-> !out_valid)
    else $error("result without item");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_out <= 13'd4096 && out_green_out <= 13'd4096
                   && out_blue_out <= 13'd4096))
    else $error("result above full scale");

endmodule

bind rgb_color_correction_pipeline_top rgbcc_checker u_rgbcc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_red_out(out_red_out), .out_green_out(out_green_out),
  .out_blue_out(out_blue_out));

// File: tb/sv/tb_rgb_color_correction_pipeline_top.sv
// testbench for the rgb color correction pipeline: directed and random pixels and settings, checked per item
`timescale 1ns / 100ps

module tb_rgb_color_correction_pipeline_top;
  import rgbcc_pkg::*;

  localparam int ONE = 4096;
  localparam int LATENCY = 14;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CH_W-1:0] in_red_in = '0;
  logic [CH_W-1:0] in_green_in = '0;
  logic [CH_W-1:0] in_blue_in = '0;
  logic out_valid;
  logic [CH_W-1:0] out_red_out;
  logic [CH_W-1:0] out_green_out;
  logic [CH_W-1:0] out_blue_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  rgb_color_correction_pipeline_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  mode_t mode;
  logic [47:0] wb, ccm_r, ccm_g, ccm_b, offs;
  logic [15:0] luma, expo;

  pixel_t pending_pixels[$];
  pixel_t corrected_pixels[$];
  int errors = 0;
  int gap = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic enqueue(input pixel_t p);
    pending_pixels = {pending_pixels, p};
  endtask

  function automatic longint curve(input bit encode, input longint v);
    longint s, idx, frac, lo, hi, q;
    s = v << 5;
    idx = s >> 12;
    frac = s & (ONE - 1);
    if (idx >= 32) q = 65536;
    else begin
      lo = encode ? encode_rom(idx[5:0]) : decode_rom(idx[5:0]);
      hi = encode ? encode_rom(idx[5:0] + 6'd1) : decode_rom(idx[5:0] + 6'd1);
      q = lo + (((hi - lo) * frac) >>> 12);
    end
    return (q * ONE + 32768) >>> 16;
  endfunction

  function automatic longint gain(input longint v, input logic [15:0] g);
    longint p;
    p = (v * longint'(g) + 2048) >>> 12;
    return p > ONE ? ONE : p;
  endfunction

  function automatic longint row(input logic [47:0] c, input int k, input longint px[3]);
    longint sum, rr;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += longint'($signed(c[16*i +: 16])) * px[i];
    if (mode[MB_OFFS]) sum += longint'($signed(offs[16*k +: 16])) * ONE;
    if (sum <= 0) return 0;
    rr = (sum + 2048) >>> 12;
    return rr > ONE ? ONE : rr;
  endfunction

  function automatic pixel_t correct(input pixel_t p);
    longint px[3], t[3];
    pixel_t o;
    px[0] = p.r; px[1] = p.g; px[2] = p.b;
    for (int i = 0; i < 3; i++) if (px[i] > ONE) px[i] = ONE;
    if (mode[MB_LIN]) for (int i = 0; i < 3; i++) px[i] = curve(0, px[i]);
    if (mode[MB_WB]) for (int i = 0; i < 3; i++) px[i] = gain(px[i], wb[16*i +: 16]);
    if (mode[MB_LUMA]) for (int i = 0; i < 3; i++) px[i] = gain(px[i], luma);
    if (mode[MB_CCM]) begin
      if (mode[MB_CENC]) for (int i = 0; i < 3; i++) px[i] = curve(1, px[i]);
      t[0] = row(ccm_r, 0, px);
      t[1] = row(ccm_g, 1, px);
      t[2] = row(ccm_b, 2, px);
      px = t;
    end
    if (mode[MB_LIN]) for (int i = 0; i < 3; i++) px[i] = curve(1, px[i]);
    if (mode[MB_EXPO]) for (int i = 0; i < 3; i++) px[i] = gain(px[i], expo);
    o.r = px[0][12:0]; o.g = px[1][12:0]; o.b = px[2][12:0];
    return o;
  endfunction

  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      corrected_pixels = {corrected_pixels, correct('{in_red_in, in_green_in, in_blue_in})};
      void'(pending_pixels.pop_front());
      gap = $urandom_range(0, 3);
    end
    if (rst_n && (!start || !busy)) begin
      if (pending_pixels.size() > 0 && gap == 0) begin
        start <= 1'b1;
        in_red_in <= pending_pixels[0].r;
        in_green_in <= pending_pixels[0].g;
        in_blue_in <= pending_pixels[0].b;
      end else begin
        start <= 1'b0;
        if (gap > 0) gap--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (corrected_pixels.size() == 0) report("result with no item pending");
      else begin
        pixel_t e;
        e = corrected_pixels.pop_front();
        if (out_red_out !== e.r) report($sformatf("red %0d exp %0d", out_red_out, e.r));
        if (out_green_out !== e.g)
          report($sformatf("green %0d exp %0d", out_green_out, e.g));
        if (out_blue_out !== e.b) report($sformatf("blue %0d exp %0d", out_blue_out, e.b));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: mode = val[6:0];
      REG_WB: wb = val;
      REG_LUMA: luma = val[15:0];
      REG_CCM_R: ccm_r = val;
      REG_CCM_G: ccm_g = val;
      REG_CCM_B: ccm_b = val;
      REG_OFFS: offs = val;
      REG_EXPO: expo = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(4096);
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  function automatic logic [47:0] rand_coefs();
    logic [47:0] c;
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 4))
        0: c[16*i +: 16] = 16'h8000;
        1: c[16*i +: 16] = 16'h7FFF;
        2: c[16*i +: 16] = 16'($urandom);
        default: c[16*i +: 16] = 16'($signed($urandom_range(0, 6000)) - 1500);
      endcase
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 13'(ONE);
      2: return 13'h1FFF;
      3: return 13'($urandom);
      default: return 13'($urandom_range(0, ONE));
    endcase
  endfunction

  task automatic drain();
    wait (pending_pixels.size() == 0 && corrected_pixels.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    mode = '0; wb = '0; luma = 16'(4096);
    ccm_r = '0; ccm_g = '0; ccm_b = '0; offs = '0; expo = 16'(4096);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // defaults: pass-through
    enqueue('{13'd0, 13'd4096, 13'h1FFF});
    enqueue('{13'h0AAA, 13'h1555, 13'd1});
    drain();
    write_reg(REG_WB, {16'd8192, 16'd4096, 16'd2048});
    write_reg(REG_LUMA, 16'hFFFF);
    write_reg(REG_CCM_R, {16'h8000, 16'h7FFF, 16'd4096});
    write_reg(REG_CCM_G, {16'hF000, 16'd4096, 16'h1000});
    write_reg(REG_CCM_B, {16'd4096, 16'hFFFF, 16'd0});
    write_reg(REG_OFFS, {16'h8000, 16'h7FFF, 16'hF800});
    write_reg(REG_EXPO, 16'd2048);
    // each mode bit, then all together, then LIN, CCM, CENC and OFFS together
    for (int m = 0; m < 9; m++) begin
      write_reg(REG_MODE, m < 7 ? mode_t'(1 << m) : (m == 7 ? mode_t'(7'h7F) : mode_t'(7'h39)));
      enqueue('{13'd4096, 13'd2048, 13'd0});
      enqueue('{13'd1, 13'd4095, 13'h1FFF});
      drain();
    end
    for (int ph = 0; ph < 15; ph++) begin
      write_reg(REG_MODE, ph == 0 ? mode_t'(0) : mode_t'($urandom));
      write_reg(REG_WB, {rand_gain(), rand_gain(), rand_gain()});
      write_reg(REG_LUMA, rand_gain());
      write_reg(REG_CCM_R, rand_coefs());
      write_reg(REG_CCM_G, rand_coefs());
      write_reg(REG_CCM_B, rand_coefs());
      write_reg(REG_OFFS, rand_coefs());
      write_reg(REG_EXPO, rand_gain());
      for (int n = 0; n < 50; n++)
        enqueue('{rand_chan(), rand_chan(), rand_chan()});
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: rgb_color_correction_pipeline_top.f
hw/rtl/rgbcc_pkg.sv
hw/rtl/rgbcc_gamma.sv
hw/rtl/rgb_color_correction_pipeline_top.sv
hw/rtl/rgbcc_checker.sv
tb/sv/tb_rgb_color_correction_pipeline_top.sv
